### rtl/core/circular_list_engine_top_assert.svh
// ----------------------------------------------------------------------------
// circular_list_engine_top_assert.svh
// Assertion macros for the circular list engine. The bodies sample on the
// rising edge of clock and stay quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_ENGINE_TOP_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define CLE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define CLE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared widths, operation codes and status codes of the circular list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

   // Default store geometry
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed port widths
   localparam int OP_W     = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 4'd0,
      OP_INS_END   = 4'd1,
      OP_INS_AFTER = 4'd2,
      OP_DEL_FRONT = 4'd3,
      OP_DEL_END   = 4'd4,
      OP_DEL_VALUE = 4'd5,
      OP_SEARCH    = 4'd6,
      OP_MAX       = 4'd7,
      OP_READ_ALL  = 4'd8
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

`default_nettype wire

### rtl/core/circular_list_engine_top.sv
// ----------------------------------------------------------------------------
// circular_list_engine_top
// Bounded ordered list of signed words with insert, delete, search, maximum
// and read-out, walked one entry per cycle through a store with one write port and one read port.
// ----------------------------------------------------------------------------
//
//   channel   ports                                     handshake
//   -------   ---------------------------------------   -------------------------
//   request   req_operation, req_value, req_position    start high, busy low
//   response  rsp_status, rsp_found, rsp_data_out,      rsp_valid, one cycle each
//             rsp_index_out, rsp_count, rsp_last
//
// One word a cycle moves through the store read port. Inserts shift the words from
// the slot on up by one, then write; appends write at once. Deletes shift later
// words down (by value after a scan); search, maximum and read-out scan the list.
// Refused inserts, empty-list operations and unused codes answer next cycle.
// Read-out words come out on consecutive cycles; the receiver cannot stall.
// Reset is synchronous and empties the list; the store itself is not cleared.
//
`timescale 1ns / 1ps
`default_nettype none

`include "circular_list_engine_top_assert.svh"

module circular_list_engine_top
   import cle_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire logic [OP_W-1:0]           req_operation,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [POS_W-1:0]          req_position,
   output      logic                      rsp_valid,
   output      logic [STATUS_W-1:0]       rsp_status,
   output      logic                      rsp_found,
   output      logic signed [VALUE_W-1:0] rsp_data_out,
   output      logic [INDEX_W-1:0]        rsp_index_out,
   output      logic [COUNT_W-1:0]        rsp_count,
   output      logic                      rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_DECIDE,
      S_MOVE,
      S_MOVE_END,
      S_COMMIT
   } state_type;

   // Control registers
   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rd_vld_ff, rd_vld_in;

   // Item and walk registers
   logic [OP_W-1:0]       op_ff, op_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]         at_ff, at_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         end_ff, end_in;
   logic [AW-1:0]         start_ff, start_in;
   logic                  dir_up_ff, dir_up_in;
   logic                  ins_ff, ins_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic [DATA_WIDTH-1:0] hit_data_ff, hit_data_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;

   // Result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Store ports
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;

   // Insert placement
   logic [CW-1:0]         at_sel;
   logic                  pos_in_range;
   logic                  scan_phase;

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_index_out = rsp_index_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   // Pick the insert slot: front, after the given element, or the end
   assign pos_in_range = (req_position != '0) && (PW'(req_position) < PW'(count_ff));
   always_comb begin
      if (req_operation == OP_INS_FRONT) begin
         at_sel = '0;
      end else if (req_operation == OP_INS_AFTER && pos_in_range) begin
         at_sel = CW'(req_position);
      end else begin
         at_sel = count_ff;
      end
   end

   assign scan_phase = (state_ff == S_SCAN) || (state_ff == S_SCAN_END);

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_vld_in     = 1'b0;
      op_in         = op_ff;
      key_in        = key_ff;
      at_in         = at_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      dir_up_in     = dir_up_ff;
      ins_in        = ins_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      rd_idx_in     = ptr_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_found_in  = 1'b0;
      rsp_data_in   = '0;
      rsp_index_in  = '0;
      rsp_last_in   = 1'b1;

      // Consume the word returned by the previous read
      if (rd_vld_ff) begin
         if (scan_phase) begin
            case (op_ff) inside
               OP_DEL_VALUE, OP_SEARCH: begin
                  if (!found_ff && rd_data_ff == key_ff) begin
                     found_in    = 1'b1;
                     hit_idx_in  = rd_idx_ff;
                     hit_data_in = rd_data_ff;
                  end
               end
               OP_MAX: begin
                  if (rd_idx_ff == '0 || $signed(rd_data_ff) > $signed(hit_data_ff)) begin
                     hit_idx_in  = rd_idx_ff;
                     hit_data_in = rd_data_ff;
                  end
               end
               OP_READ_ALL: begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = VALUE_W'(rd_data_ff);
                  rsp_index_in = INDEX_W'(rd_idx_ff);
                  rsp_last_in  = (rd_idx_ff == end_ff);
               end
               default: ;
            endcase
         end else if (ins_ff) begin
            // Shift toward the end to open the insert slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_idx_ff + AW'(1);
            mem_wr_data = rd_data_ff;
         end else if (rd_idx_ff == start_ff) begin
            // Hold the word being removed
            hit_data_in = rd_data_ff;
         end else begin
            // Shift toward the front to close the gap
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_idx_ff - AW'(1);
            mem_wr_data = rd_data_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               key_in   = DATA_WIDTH'(req_value);
               found_in = 1'b0;
               unique case (req_operation) inside
                  OP_INS_FRONT, OP_INS_END, OP_INS_AFTER: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        at_in     = AW'(at_sel);
                        ins_in    = 1'b1;
                        dir_up_in = 1'b0;
                        ptr_in    = AW'(count_ff - CW'(1));
                        end_in    = AW'(at_sel);
                        state_in  = (at_sel < count_ff) ? S_MOVE : S_COMMIT;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_END, OP_DEL_VALUE, OP_SEARCH, OP_MAX,
                  OP_READ_ALL: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ins_in    = 1'b0;
                        dir_up_in = 1'b1;
                        end_in    = AW'(count_ff - CW'(1));
                        if (req_operation == OP_DEL_FRONT) begin
                           ptr_in   = '0;
                           start_in = '0;
                           state_in = S_MOVE;
                        end else if (req_operation == OP_DEL_END) begin
                           ptr_in   = AW'(count_ff - CW'(1));
                           start_in = AW'(count_ff - CW'(1));
                           state_in = S_MOVE;
                        end else begin
                           ptr_in   = '0;
                           state_in = S_SCAN;
                        end
                     end
                  end
                  default: begin
                     // Unused codes answer ok and leave the list alone
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN, S_MOVE: begin
            // Issue one read a cycle until the walk reaches its end
            mem_rd_en = 1'b1;
            rd_vld_in = 1'b1;
            if (ptr_ff == end_ff) begin
               state_in = (state_ff == S_SCAN) ? S_SCAN_END : S_MOVE_END;
            end else begin
               ptr_in = dir_up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
            end
         end

         S_SCAN_END: begin
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            state_in = S_IDLE;
            case (op_ff) inside
               OP_SEARCH, OP_MAX: begin
                  rsp_valid_in = 1'b1;
                  if (op_ff == OP_SEARCH && !found_ff) begin
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     rsp_found_in = (op_ff == OP_SEARCH);
                     rsp_data_in  = VALUE_W'(hit_data_ff);
                     rsp_index_in = INDEX_W'(hit_idx_ff);
                  end
               end
               OP_DEL_VALUE: begin
                  if (found_ff) begin
                     ptr_in   = hit_idx_ff;
                     start_in = hit_idx_ff;
                     state_in = S_MOVE;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               default: ;
            endcase
         end

         S_MOVE_END: begin
            state_in = S_COMMIT;
         end

         S_COMMIT: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (ins_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = at_ff;
               mem_wr_data = key_ff;
               count_in    = count_ff + CW'(1);
            end else begin
               count_in     = count_ff - CW'(1);
               rsp_found_in = (op_ff == OP_DEL_VALUE);
               rsp_data_in  = VALUE_W'(hit_data_ff);
               rsp_index_in = INDEX_W'(start_ff);
            end
         end

         default: state_in = S_IDLE;
      endcase

      rsp_count_in = COUNT_W'(count_in);
   end

   // Store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      at_ff         <= at_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      start_ff      <= start_in;
      dir_up_ff     <= dir_up_in;
      ins_ff        <= ins_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_data_ff   <= hit_data_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   `CLE_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "element count beyond depth")
   `CLE_ASSERT_IMP(a_count_step, count_ff != $past(count_ff),
      (count_ff == CW'($past(count_ff) + 1'b1)) || (count_ff == CW'($past(count_ff) - 1'b1)),
      "count moved by more than one")
   `CLE_ASSERT_NXT(a_full_refuse,
      start && !busy && count_ff == CW'(DEPTH) && (req_operation == OP_INS_FRONT ||
      req_operation == OP_INS_END || req_operation == OP_INS_AFTER),
      rsp_valid && rsp_status == ST_FULL, "insert into full list not refused")
   `CLE_ASSERT_NXT(a_readout_burst, rsp_valid && !rsp_last, rsp_valid, "read-out burst broke off")
   `CLE_ASSERT_IMP(a_idle_no_write, state_ff == S_IDLE, !mem_wr_en, "store written while idle")

endmodule

`default_nettype wire
